### src/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants of the feedback-queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_ADMIT = 3'd1;
    localparam logic [2:0] FUNC_WAKE  = 3'd2;
    localparam logic [2:0] FUNC_BLOCK = 3'd3;
    localparam logic [2:0] FUNC_EXIT  = 3'd4;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_BLOCK = 2'd3;

    localparam logic [2:0] TOP_LEVEL = 3'd4;

    localparam logic CFG_AGING  = 1'b0;
    localparam logic CFG_LOWEST = 1'b1;

    // One word of the slot table
    typedef struct packed {
        logic [1:0]  st;
        logic [2:0]  lvl;
        logic [31:0] et;
    } slot_entry_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;      // latch event and read its slot
        logic apply;      // apply the latched event
        logic disp_start; // clear selection
        logic scan_rd;    // read one slot of the scan
        logic commit;     // dispatch the best slot
        logic scan_inc;   // advance scan index
        logic scan_clr;   // clear scan index
        logic clear_step; // empty one slot after reset
    } mlfq_cmd_t;

    typedef struct packed {
        logic run_valid;
        logic scan_last;
    } mlfq_stat_t;

endpackage

### src/mlfq_process_scheduler_core.sv
// ----------------------------------------------------------------------------
// mlfq_process_scheduler_core
// Five-level feedback-queue process scheduler.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one event: func and slot.
// Output channel (out_valid/out_ready) returns one result per event: the
// running slot, its level and slice, the aging flag and the reject flag.
// One event is handled at a time. An event that leaves a slot running shows
// its result after the apply and decide states. One that leaves the CPU free
// runs a single scan over the slot table that ages (when the running slot
// gave way) and selects together, one slot read per cycle, followed by the
// last and pick states. The next event is taken in the cycle after the
// result transfer. The result is held until out_ready; no new event is
// taken meanwhile. Reset zeroes the clock and restores the registers:
// aging_multiplier 5, lowest_level 4; a clearing pass then empties every
// slot before in_ready rises. Configuration writes via cfg_we, cfg_index,
// cfg_data take effect at once.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler_core
    import mlfq_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic [5:0] slot,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       running_valid,
    output logic [5:0] running_slot,
    output logic [2:0] running_level,
    output logic [4:0] slice_left,
    output logic       aged_any,
    output logic       rejected
);

    mlfq_cmd_t  cmd;
    mlfq_stat_t stat;

    mlfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mlfq_dpath #(.SLOTS(SLOTS)) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .slot          (slot),
        .cmd           (cmd),
        .stat          (stat),
        .running_valid (running_valid),
        .running_slot  (running_slot),
        .running_level (running_level),
        .slice_left    (slice_left),
        .aged_any      (aged_any),
        .rejected      (rejected)
    );

endmodule

### src/mlfq_ctrl.sv
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: table clear, event, combined aging and dispatch scan, result.
// ----------------------------------------------------------------------------
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  mlfq_stat_t stat,
    output mlfq_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b00000001,
        S_IDLE   = 8'b00000010,
        S_APPLY  = 8'b00000100,
        S_DECIDE = 8'b00001000,
        S_SCAN   = 8'b00010000,
        S_LAST   = 8'b00100000,
        S_PICK   = 8'b01000000,
        S_OUT    = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                cmd.scan_inc   = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.scan_clr = 1'b1;
                if (!stat.run_valid)
                begin
                    cmd.disp_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.scan_inc = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                // last slot read is evaluated here
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/mlfq_dpath.sv
// ----------------------------------------------------------------------------
// mlfq_dpath
// Slot table, clock, running slot and the serial aging and selection unit.
// ----------------------------------------------------------------------------
module mlfq_dpath
    import mlfq_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    input  logic [2:0] func,
    input  logic [5:0] slot,
    input  mlfq_cmd_t  cmd,
    output mlfq_stat_t stat,
    output logic       running_valid,
    output logic [5:0] running_slot,
    output logic [2:0] running_level,
    output logic [4:0] slice_left,
    output logic       aged_any,
    output logic       rejected
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    slot_entry_t   slot_mem [SLOTS];
    slot_entry_t   rd_reg;
    logic [31:0]   now_reg;
    logic          run_reg;
    logic [IW-1:0] run_idx_reg;
    logic [2:0]    run_lvl_reg;
    logic [4:0]    slice_reg;
    logic [3:0]    mult_reg;
    logic [2:0]    lowest_reg;
    logic [2:0]    func_reg;
    logic [5:0]    slot_reg;
    logic          yield_reg;
    logic          aged_reg;
    logic          rej_reg;
    logic [IW-1:0] scan_reg;
    logic [IW-1:0] pipe_idx_reg;
    logic          pipe_vld_reg;
    logic          found_reg;
    logic [IW-1:0] best_reg;
    logic [2:0]    best_lvl_reg;
    logic [31:0]   best_age_reg;

    logic [2:0]    floor_lvl;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] ev_idx;
    logic          slot_ok;
    logic [31:0]   s_age;
    logic [35:0]   limit;
    logic          promote;
    logic [2:0]    p_lvl;
    logic [2:0]    p_lvl_c;
    logic [31:0]   p_age;
    logic          better;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    slot_entry_t   wr_data;
    logic          ev_reject;
    logic          ev_yield;

    assign floor_lvl = (lowest_reg > TOP_LEVEL) ? TOP_LEVEL : lowest_reg;
    assign ev_idx    = IW'(slot_reg);
    assign slot_ok   = ({26'd0, slot_reg} < 32'(SLOTS));
    assign rd_addr   = cmd.start ? IW'(slot) : scan_reg;

    // aging and selection act on the word read in the previous cycle
    assign s_age     = now_reg - rd_reg.et;
    assign limit     = {32'd0, mult_reg} << rd_reg.lvl;
    assign promote   = yield_reg && (rd_reg.st == ST_READY) && (rd_reg.lvl != 3'd0)
                       && (rd_reg.lvl <= TOP_LEVEL) && ({4'd0, s_age} > limit);
    assign p_lvl     = promote ? (rd_reg.lvl - 3'd1) : rd_reg.lvl;
    assign p_age     = promote ? 32'd0 : s_age;
    assign p_lvl_c   = (p_lvl > TOP_LEVEL) ? TOP_LEVEL : p_lvl;
    assign better    = (rd_reg.st == ST_READY) && (!found_reg || (p_lvl_c < best_lvl_reg)
                       || ((p_lvl_c == best_lvl_reg) && (p_age > best_age_reg)));

    assign stat.run_valid = run_reg;
    assign stat.scan_last = (scan_reg == IW'(SLOTS - 1));

    // single write port of the slot table
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = run_idx_reg;
        wr_data   = '0;
        ev_reject = 1'b0;
        ev_yield  = 1'b0;
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = scan_reg;
        end
        else if (cmd.apply)
        begin
            unique case (func_reg)
                FUNC_TICK:
                begin
                    if (run_reg && (slice_reg <= 5'd1))
                    begin
                        wr_en      = 1'b1;
                        wr_data.st = ST_READY;
                        wr_data.lvl = (run_lvl_reg < floor_lvl) ? (run_lvl_reg + 3'd1)
                                                                : run_lvl_reg;
                        wr_data.et = now_reg + 32'd1;
                        ev_yield   = 1'b1;
                    end
                end
                FUNC_ADMIT:
                begin
                    if (!slot_ok || rd_reg.st != ST_EMPTY)
                    begin
                        ev_reject = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = ev_idx;
                        wr_data.st  = ST_READY;
                        wr_data.lvl = 3'd0;
                        wr_data.et  = now_reg;
                    end
                end
                FUNC_WAKE:
                begin
                    if (!slot_ok || rd_reg.st != ST_BLOCK)
                    begin
                        ev_reject = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = ev_idx;
                        wr_data.st  = ST_READY;
                        wr_data.lvl = rd_reg.lvl;
                        wr_data.et  = now_reg;
                    end
                end
                FUNC_BLOCK, FUNC_EXIT:
                begin
                    if (!run_reg)
                    begin
                        ev_reject = 1'b1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        ev_yield = 1'b1;
                        wr_data.et = now_reg;
                        if (func_reg == FUNC_BLOCK)
                        begin
                            wr_data.st  = ST_BLOCK;
                            wr_data.lvl = run_lvl_reg;
                        end
                        else
                        begin
                            wr_data.st  = ST_EMPTY;
                            wr_data.lvl = 3'd0;
                        end
                    end
                end
                default:
                begin
                    ev_reject = 1'b1;
                end
            endcase
        end
        else if (pipe_vld_reg && promote)
        begin
            wr_en       = 1'b1;
            wr_addr     = pipe_idx_reg;
            wr_data.st  = ST_READY;
            wr_data.lvl = rd_reg.lvl - 3'd1;
            wr_data.et  = now_reg;
        end
        else if (cmd.commit && found_reg)
        begin
            wr_en       = 1'b1;
            wr_addr     = best_reg;
            wr_data.st  = ST_RUN;
            wr_data.lvl = best_lvl_reg;
            wr_data.et  = now_reg - best_age_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (cmd.start || cmd.scan_rd)
        begin
            rd_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg      <= 32'd0;
            run_reg      <= 1'b0;
            run_idx_reg  <= '0;
            run_lvl_reg  <= 3'd0;
            slice_reg    <= 5'd0;
            mult_reg     <= 4'd5;
            lowest_reg   <= 3'd4;
            func_reg     <= FUNC_TICK;
            slot_reg     <= 6'd0;
            yield_reg    <= 1'b0;
            aged_reg     <= 1'b0;
            rej_reg      <= 1'b0;
            scan_reg     <= '0;
            pipe_idx_reg <= '0;
            pipe_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            best_lvl_reg <= 3'd0;
            best_age_reg <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_AGING)
                begin
                    mult_reg <= cfg_data;
                end
                else
                begin
                    lowest_reg <= cfg_data[2:0];
                end
            end
            if (cmd.start)
            begin
                func_reg  <= func;
                slot_reg  <= slot;
                yield_reg <= 1'b0;
                rej_reg   <= 1'b0;
                aged_reg  <= 1'b0;
            end
            if (cmd.apply)
            begin
                rej_reg   <= ev_reject;
                yield_reg <= ev_yield;
                if (func_reg == FUNC_TICK)
                begin
                    now_reg <= now_reg + 32'd1;
                end
                if (ev_yield)
                begin
                    run_reg   <= 1'b0;
                    slice_reg <= 5'd0;
                end
                else if ((func_reg == FUNC_TICK) && run_reg)
                begin
                    slice_reg <= slice_reg - 5'd1;
                end
            end
            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + IW'(1);
            end
            pipe_vld_reg <= cmd.scan_rd;
            if (cmd.scan_rd)
            begin
                pipe_idx_reg <= scan_reg;
            end
            if (pipe_vld_reg && promote)
            begin
                aged_reg <= 1'b1;
            end
            if (cmd.disp_start)
            begin
                found_reg <= 1'b0;
            end
            if (pipe_vld_reg && better)
            begin
                found_reg    <= 1'b1;
                best_reg     <= pipe_idx_reg;
                best_lvl_reg <= p_lvl_c;
                best_age_reg <= p_age;
            end
            if (cmd.commit && found_reg)
            begin
                run_reg     <= 1'b1;
                run_idx_reg <= best_reg;
                run_lvl_reg <= best_lvl_reg;
                slice_reg   <= 5'd1 << best_lvl_reg;
            end
        end
    end

    assign running_valid = run_reg;
    assign running_slot  = run_reg ? 6'(run_idx_reg) : 6'd0;
    assign running_level = run_reg ? run_lvl_reg : 3'd0;
    assign slice_left    = run_reg ? slice_reg : 5'd0;
    assign aged_any      = aged_reg;
    assign rejected      = rej_reg;

endmodule

### src/mlfq_checker.sv
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks on the scheduler's results.
// ----------------------------------------------------------------------------
module mlfq_checker
    import mlfq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       running_valid,
    input logic [5:0] running_slot,
    input logic [2:0] running_level,
    input logic [4:0] slice_left,
    input logic       aged_any,
    input logic       rejected
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("event taken while a result waits");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !running_valid) |->
            (running_slot == 6'd0 && running_level == 3'd0 && slice_left == 5'd0))
        else $error("idle result carries fields");

    a_slice_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && running_valid) |->
            (slice_left != 5'd0 && slice_left <= 5'd16 && running_level <= TOP_LEVEL))
        else $error("slice or level out of range");

    a_reject_no_age: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> !aged_any)
        else $error("rejected event aged slots");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(running_slot)))
        else $error("stalled result changed");

endmodule

bind mlfq_process_scheduler_core mlfq_checker u_mlfq_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the feedback-queue scheduler core. Events go in on
// a valid/ready channel from a queue; a scheduler model in the bench predicts
// each result and the monitor compares every returned transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import mlfq_pkg::*;

    localparam int NSLOT     = 64;
    localparam int LIMIT_CYC = 2_000_000;
    localparam int HOLD_CYC  = 600;

    typedef struct packed {
        logic [2:0] fn;
        logic [5:0] sl;
    } sched_event_t;

    typedef struct packed {
        logic       rv;
        logic [5:0] rs;
        logic [2:0] rl;
        logic [4:0] sli;
        logic       ag;
        logic       rj;
    } sched_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] func;
    logic [5:0] slot;
    logic       out_valid;
    logic       out_ready;
    logic       running_valid;
    logic [5:0] running_slot;
    logic [2:0] running_level;
    logic [4:0] slice_left;
    logic       aged_any;
    logic       rejected;

    mlfq_process_scheduler_core #(.SLOTS(NSLOT)) i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .slot(slot), .out_valid(out_valid), .out_ready(out_ready),
        .running_valid(running_valid), .running_slot(running_slot),
        .running_level(running_level), .slice_left(slice_left),
        .aged_any(aged_any), .rejected(rejected)
    );

    // scheduler model state
    logic [1:0]  m_status [NSLOT];
    logic [2:0]  m_level  [NSLOT];
    logic [31:0] m_entry  [NSLOT];
    logic [31:0] m_now;
    logic        m_run;
    int          m_cur;
    logic [4:0]  m_slice;
    logic [3:0]  m_mult;
    logic [2:0]  m_lowest;

    sched_event_t  pending_events [$];
    sched_result_t expected_results [$];
    int  errors, cycles, accepted, returned, stall_left, launched;
    int  send_idle_pct, recv_idle_pct;
    logic hold_recv;

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic age_ready_slots();
        logic any;
        any = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            if (m_status[i] == ST_READY && m_level[i] != 0 && m_level[i] <= TOP_LEVEL) begin
                if ((m_now - m_entry[i]) > 32'(m_mult) * (32'd1 << m_level[i])) begin
                    m_level[i] = m_level[i] - 3'd1;
                    m_entry[i] = m_now;
                    any = 1'b1;
                end
            end
        end
        return any;
    endfunction

    function automatic void pick_next();
        logic found;
        int best;
        logic [2:0] blvl, lvl;
        logic [31:0] bage, age;
        found = 1'b0;
        best = 0;
        blvl = 0;
        bage = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (m_status[i] == ST_READY) begin
                lvl = (m_level[i] > TOP_LEVEL) ? TOP_LEVEL : m_level[i];
                age = m_now - m_entry[i];
                if (!found || lvl < blvl || (lvl == blvl && age > bage)) begin
                    found = 1'b1;
                    best = i;
                    blvl = lvl;
                    bage = age;
                end
            end
        end
        if (found) begin
            m_status[best] = ST_RUN;
            m_level[best] = blvl;
            m_run = 1'b1;
            m_cur = best;
            m_slice = 5'd1 << blvl;
        end
    endfunction

    function automatic sched_result_t schedule_event(sched_event_t ev);
        sched_result_t r;
        logic rj, ag, yl;
        logic [2:0] floor_lvl;
        rj = 1'b0;
        ag = 1'b0;
        yl = 1'b0;
        floor_lvl = (m_lowest > TOP_LEVEL) ? TOP_LEVEL : m_lowest;
        case (ev.fn)
            FUNC_TICK: begin
                m_now = m_now + 32'd1;
                if (m_run) begin
                    if (m_slice <= 5'd1) begin
                        m_slice = 0;
                        if (m_level[m_cur] < floor_lvl)
                            m_level[m_cur] = m_level[m_cur] + 3'd1;
                        m_entry[m_cur] = m_now;
                        m_status[m_cur] = ST_READY;
                        m_run = 1'b0;
                        yl = 1'b1;
                    end
                    else
                        m_slice = m_slice - 5'd1;
                end
            end
            FUNC_ADMIT: begin
                if (m_status[ev.sl] != ST_EMPTY)
                    rj = 1'b1;
                else
                begin
                    m_status[ev.sl] = ST_READY;
                    m_level[ev.sl] = 0;
                    m_entry[ev.sl] = m_now;
                end
            end
            FUNC_WAKE: begin
                if (m_status[ev.sl] != ST_BLOCK)
                    rj = 1'b1;
                else
                begin
                    m_status[ev.sl] = ST_READY;
                    m_entry[ev.sl] = m_now;
                end
            end
            FUNC_BLOCK, FUNC_EXIT: begin
                if (!m_run)
                    rj = 1'b1;
                else
                begin
                    if (ev.fn == FUNC_BLOCK)
                        m_status[m_cur] = ST_BLOCK;
                    else
                    begin
                        m_status[m_cur] = ST_EMPTY;
                        m_level[m_cur] = 0;
                    end
                    m_run = 1'b0;
                    m_slice = 0;
                    yl = 1'b1;
                end
            end
            default: rj = 1'b1;
        endcase
        if (yl)
            ag = age_ready_slots();
        if (!m_run)
            pick_next();
        r.rv  = m_run;
        r.rs  = m_run ? 6'(m_cur) : 6'd0;
        r.rl  = m_run ? m_level[m_cur] : 3'd0;
        r.sli = m_run ? m_slice : 5'd0;
        r.ag  = ag;
        r.rj  = rj;
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            func <= FUNC_TICK;
            slot <= '0;
        end
        else
        begin
            if (in_valid && in_ready) begin
                expected_results.push_back(schedule_event('{fn: func, sl: slot}));
                accepted <= accepted + 1;
            end
            if ((!in_valid || in_ready) ) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    sched_event_t ev;
                    ev = pending_events.pop_front();
                    in_valid <= 1'b1;
                    func <= ev.fn;
                    slot <= ev.sl;
                    launched <= launched + 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall counter and ready
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_recv) begin
            stall_left <= HOLD_CYC;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n) begin
            cycles <= cycles + 1;
            if (out_valid && out_ready) begin
                returned <= returned + 1;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    sched_result_t e;
                    int bad;
                    bad = 0;
                    e = expected_results.pop_front();
                    if (running_valid !== e.rv) begin
                        $error("running_valid exp %0d got %0d", e.rv, running_valid);
                        bad = bad + 1;
                    end
                    if (running_slot !== e.rs) begin
                        $error("running_slot exp %0d got %0d", e.rs, running_slot);
                        bad = bad + 1;
                    end
                    if (running_level !== e.rl) begin
                        $error("running_level exp %0d got %0d", e.rl, running_level);
                        bad = bad + 1;
                    end
                    if (slice_left !== e.sli) begin
                        $error("slice_left exp %0d got %0d", e.sli, slice_left);
                        bad = bad + 1;
                    end
                    if (aged_any !== e.ag) begin
                        $error("aged_any exp %0d got %0d", e.ag, aged_any);
                        bad = bad + 1;
                    end
                    if (rejected !== e.rj) begin
                        $error("rejected exp %0d got %0d", e.rj, rejected);
                        bad = bad + 1;
                    end
                    errors <= errors + bad;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (cycles >= LIMIT_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_event(logic [2:0] fn, logic [5:0] sl);
        sched_event_t ev;
        ev.fn = fn;
        ev.sl = sl;
        pending_events.push_back(ev);
    endtask

    task automatic wait_drained();
        while (pending_events.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (2 * NSLOT + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_AGING)
            m_mult = val;
        else
            m_lowest = val[2:0];
    endtask

    // random bursts: ticks most often, with admits and wakes to slots 0..15
    // and blocks and exits mixed in; a slice of noise events
    task automatic random_burst(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 45)
                add_event(FUNC_TICK, 6'($urandom));
            else if (k < 60)
                add_event(FUNC_ADMIT, 6'($urandom_range(15)));
            else if (k < 70)
                add_event(FUNC_WAKE, 6'($urandom_range(15)));
            else if (k < 80)
                add_event(FUNC_BLOCK, 6'($urandom));
            else if (k < 88)
                add_event(FUNC_EXIT, 6'($urandom));
            else if (k < 94)
                add_event(3'($urandom_range(7)), 6'($urandom));
            else
                add_event(FUNC_ADMIT, 6'($urandom));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_AGING;
        cfg_data = '0;
        hold_recv = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        errors = 0;
        cycles = 0;
        accepted = 0;
        returned = 0;
        launched = 0;
        for (int i = 0; i < NSLOT; i++) begin
            m_status[i] = ST_EMPTY;
            m_level[i] = 0;
            m_entry[i] = 0;
        end
        m_now = 0;
        m_run = 1'b0;
        m_cur = 0;
        m_slice = 0;
        m_mult = 4'd5;
        m_lowest = 3'd4;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: rejects when idle, admits at both slot extremes, unknown
        // codes, ticks through slices and demotion, block/wake, exit
        add_event(FUNC_BLOCK, 6'd0);
        add_event(FUNC_EXIT, 6'd0);
        add_event(FUNC_TICK, 6'd0);
        add_event(FUNC_WAKE, 6'd63);
        add_event(FUNC_ADMIT, 6'd63);
        add_event(FUNC_ADMIT, 6'd0);
        add_event(FUNC_ADMIT, 6'd0);
        add_event(3'd5, 6'd21);
        add_event(3'd6, 6'd42);
        add_event(3'd7, 6'd63);
        for (int i = 0; i < 8; i++)
            add_event(FUNC_TICK, 6'h2a);
        add_event(FUNC_BLOCK, 6'd0);
        add_event(FUNC_WAKE, 6'd63);
        add_event(FUNC_WAKE, 6'd0);
        add_event(FUNC_EXIT, 6'd0);
        add_event(FUNC_TICK, 6'h15);
        add_event(FUNC_EXIT, 6'd0);
        wait_drained();

        // no idling, reset settings
        random_burst(300);
        wait_drained();

        write_reg(CFG_AGING, 4'd0);
        write_reg(CFG_LOWEST, 4'd0);
        send_idle_pct = 50;
        random_burst(250);
        wait_drained();

        write_reg(CFG_AGING, 4'd15);
        write_reg(CFG_LOWEST, 4'd7);
        send_idle_pct = 0;
        recv_idle_pct = 50;
        random_burst(300);
        wait_drained();

        write_reg(CFG_AGING, 4'd1);
        write_reg(CFG_LOWEST, 4'd4);
        send_idle_pct = 18;
        recv_idle_pct = 18;
        random_burst(300);
        // long receiver hold while the sender keeps offering
        hold_recv <= 1'b1;
        @(posedge clk);
        hold_recv <= 1'b0;
        wait_drained();

        write_reg(CFG_AGING, 4'd3);
        write_reg(CFG_LOWEST, 4'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(250);
        wait_drained();

        write_reg(CFG_AGING, 4'd8);
        write_reg(CFG_LOWEST, 4'd5);
        send_idle_pct = 50;
        recv_idle_pct = 50;
        random_burst(250);
        wait_drained();

        $display("sent %0d events (%0d taken), %0d results checked, over six register settings",
                 launched, accepted, returned);
        $display("with sender gaps, receiver stalls and one long receiver hold");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
src/mlfq_pkg.sv
src/mlfq_ctrl.sv
src/mlfq_dpath.sv
src/mlfq_process_scheduler_core.sv
src/mlfq_checker.sv
tb/tb_top.sv
